>>> src/mbb_pkg.sv
// Shared constants and types for the monochrome bitmap blit unit.
// No dependencies; imported by mbb_ctrl, mbb_dp, the top level and the testbench.
package mbb_pkg;

    // Frame buffer geometry. Each byte holds eight vertical pixels.
    localparam int COLUMNS    = 128;
    localparam int PAGES      = 8;
    localparam int ROWS       = PAGES * 8;
    localparam int STORE_SIZE = COLUMNS * PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);

    // Configuration register indexes.
    localparam logic [1:0] CFG_X_ORIGIN   = 2'd0;
    localparam logic [1:0] CFG_Y_ORIGIN   = 2'd1;
    localparam logic [1:0] CFG_BMP_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_BMP_HEIGHT = 2'd3;

    // Transaction kinds on s_cmd.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [7:0] PIXEL_MASK = 8'h01;

    // Bit counter for the read-modify-write loop: eight reads plus one final write.
    localparam int BIT_CNT_W = 4;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = 4'd8;

    typedef struct packed {
        logic                 clear;
        logic                 accept_wr;
        logic                 accept_rd;
        logic                 prep;
        logic                 bits;
        logic [BIT_CNT_W-1:0] bit_idx;
        logic                 load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic skip;
        logic out_valid;
    } ctrl_stat_t;

endpackage

>>> src/mbb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/mbb_ctrl.sv
// Controller state machine of the bitmap blit unit.
// Depends on mbb_pkg; drives the datapath through ctrl_cmd_t.
module mbb_ctrl import mbb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_cmd,
    input  logic       m_ready,
    input  ctrl_stat_t stat,
    output logic       s_ready,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PREP  = 5'b00100,
        ST_BITS  = 5'b01000,
        ST_READ  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    always_comb begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.bit_idx  = bit_cnt_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // A read needs the output register to be free when its data lands.
                s_ready = (s_cmd == CMD_READ) ? (!stat.out_valid || m_ready) : 1'b1;
                if (s_valid && s_ready) begin
                    if (s_cmd == CMD_READ) begin
                        cmd.accept_rd = 1'b1;
                        state_next    = ST_READ;
                    end else begin
                        cmd.accept_wr = 1'b1;
                        state_next    = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep     = 1'b1;
                bit_cnt_next = '0;
                state_next   = stat.skip ? ST_IDLE : ST_BITS;
            end
            ST_BITS: begin
                cmd.bits = 1'b1;
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = ST_IDLE;
                end else begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_READ: begin
                cmd.load_out = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            bit_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

>>> src/mbb_dp.sv
// Datapath of the bitmap blit unit: registers, bitmap position, frame RAM.
// Depends on mbb_pkg and mbb_ram; steered by mbb_ctrl through ctrl_cmd_t.
module mbb_dp import mbb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_start_req,
    input  logic [7:0]  s_pixel_byte,
    input  logic [9:0]  s_read_index,
    input  logic        m_ready,
    input  ctrl_cmd_t   cmd,
    output ctrl_stat_t  stat,
    output logic        m_valid,
    output logic [7:0]  m_frame_byte
);

    logic [7:0] x_origin_reg, x_origin_next;
    logic [7:0] y_origin_reg, y_origin_next;
    logic [7:0] bmp_width_reg, bmp_width_next;
    logic [7:0] bmp_height_reg, bmp_height_next;

    logic [4:0] byte_in_row_reg, byte_in_row_next;
    logic [7:0] row_count_reg, row_count_next;
    logic       blit_done_reg, blit_done_next;

    logic [7:0] data_reg, data_next;
    logic       rd_oor_reg, rd_oor_next;

    logic              pend_en_reg, pend_en_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_on_reg, pend_on_next;
    logic [2:0]        pend_bit_reg, pend_bit_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;

    logic [7:0]        pix_idx, pix_x, pix_y, row_inc;
    logic              x_ok, y_ok, in_width, last_bit, issue, row_end, ignore;
    logic [5:0]        row_bytes;
    logic [ADDR_W-1:0] bit_addr, ram_raddr, ram_waddr;
    logic [7:0]        ram_rdata, ram_wdata, mask, merged;
    logic              ram_we;

    // Pixel under the current loop step; the row offset is shared by all eight bits.
    assign last_bit = (cmd.bit_idx == LAST_BIT);
    assign issue    = cmd.bits && !last_bit;
    assign pix_idx  = {byte_in_row_reg, cmd.bit_idx[2:0]};
    assign pix_x    = x_origin_reg + pix_idx;
    assign pix_y    = y_origin_reg + row_count_reg;
    assign x_ok     = ({1'b0, pix_x} < 9'(COLUMNS));
    assign y_ok     = ({1'b0, pix_y} < 9'(ROWS));
    assign in_width = (pix_idx < bmp_width_reg);
    assign bit_addr = ADDR_W'(32'(pix_x) * PAGES + 32'(pix_y[7:3]));

    assign row_bytes = 6'((9'(bmp_width_reg) + 9'd7) >> 3);
    assign row_end   = ((6'(byte_in_row_reg) + 6'd1) >= row_bytes);
    assign row_inc   = row_count_reg + 8'd1;
    assign ignore    = blit_done_reg || (bmp_width_reg == 8'd0) || (bmp_height_reg == 8'd0);

    assign stat.skip       = ignore || (row_count_reg >= bmp_height_reg);
    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(STORE_SIZE - 1));
    assign stat.out_valid  = out_valid_reg;

    // The read of the next pixel overlaps the write-back of the previous one.
    assign mask      = PIXEL_MASK << pend_bit_reg;
    assign merged    = pend_on_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
    assign ram_raddr = issue ? bit_addr : ADDR_W'(s_read_index);
    assign ram_we    = cmd.clear || pend_en_reg;
    assign ram_waddr = cmd.clear ? clr_cnt_reg : pend_addr_reg;
    assign ram_wdata = cmd.clear ? 8'd0 : merged;

    mbb_ram #(
        .WIDTH(8),
        .DEPTH(STORE_SIZE)
    ) u_frame_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        x_origin_next    = x_origin_reg;
        y_origin_next    = y_origin_reg;
        bmp_width_next   = bmp_width_reg;
        bmp_height_next  = bmp_height_reg;
        byte_in_row_next = byte_in_row_reg;
        row_count_next   = row_count_reg;
        blit_done_next   = blit_done_reg;
        data_next        = data_reg;
        rd_oor_next      = rd_oor_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_X_ORIGIN:   x_origin_next   = cfg_wdata;
                CFG_Y_ORIGIN:   y_origin_next   = cfg_wdata;
                CFG_BMP_WIDTH:  bmp_width_next  = cfg_wdata;
                CFG_BMP_HEIGHT: bmp_height_next = cfg_wdata;
                default:        x_origin_next   = x_origin_reg;
            endcase
        end

        if (cmd.clear) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (cmd.accept_wr) begin
            data_next = s_pixel_byte;
            if (s_start_req) begin
                byte_in_row_next = 5'd0;
                row_count_next   = 8'd0;
                blit_done_next   = 1'b0;
            end
        end

        if (cmd.accept_rd) begin
            rd_oor_next = (32'(s_read_index) >= STORE_SIZE);
        end

        // A byte that arrives once all rows are in only marks the bitmap as done.
        if (cmd.prep && !ignore && (row_count_reg >= bmp_height_reg)) begin
            blit_done_next = 1'b1;
        end

        if (cmd.bits && last_bit) begin
            if (row_end) begin
                byte_in_row_next = 5'd0;
                row_count_next   = row_inc;
                if (row_inc >= bmp_height_reg) begin
                    blit_done_next = 1'b1;
                end
            end else begin
                byte_in_row_next = byte_in_row_reg + 5'd1;
            end
        end

        pend_en_next   = issue && in_width && x_ok && y_ok;
        pend_addr_next = bit_addr;
        pend_on_next   = data_reg[~cmd.bit_idx[2:0]];
        pend_bit_next  = pix_y[2:0];

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
            out_data_next  = rd_oor_reg ? 8'd0 : ram_rdata;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg    <= 8'd0;
            y_origin_reg    <= 8'd0;
            bmp_width_reg   <= 8'd0;
            bmp_height_reg  <= 8'd0;
            byte_in_row_reg <= 5'd0;
            row_count_reg   <= 8'd0;
            blit_done_reg   <= 1'b0;
            pend_en_reg     <= 1'b0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            x_origin_reg    <= x_origin_next;
            y_origin_reg    <= y_origin_next;
            bmp_width_reg   <= bmp_width_next;
            bmp_height_reg  <= bmp_height_next;
            byte_in_row_reg <= byte_in_row_next;
            row_count_reg   <= row_count_next;
            blit_done_reg   <= blit_done_next;
            pend_en_reg     <= pend_en_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg      <= data_next;
        rd_oor_reg    <= rd_oor_next;
        pend_addr_reg <= pend_addr_next;
        pend_on_reg   <= pend_on_next;
        pend_bit_reg  <= pend_bit_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_data_reg;

endmodule

>>> src/mono_bitmap_blit_to_page_buffer_unit.sv
// Top level of the monochrome bitmap blit unit.
// Depends on mbb_pkg, mbb_ctrl, mbb_dp (and mbb_ram below it).
//
// Streams a 1-bit bitmap into a 128-column by 8-page frame buffer and reads
// buffer bytes back. After reset the unit clears the frame RAM one byte per
// cycle with s_ready low; configuration writes are taken during that time. A
// bitmap byte (s_cmd = 0) goes from idle through ST_PREP and ST_BITS back to
// idle before the next s_ready: its eight pixels land in eight different
// columns, and each is a read-modify-write through the single frame RAM, whose
// one read port and one write port overlap the read of one pixel with the
// write-back of the one before. An ignored byte (bitmap finished, zero width
// or height) returns from ST_PREP to idle. A read (s_cmd = 1) passes the RAM's
// registered read port and ST_READ onto m_frame_byte, and the unit is idle
// again as it shows; the output register holds a result until it is taken.
module mono_bitmap_blit_to_page_buffer_unit import mbb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    input  logic       s_start_req,
    input  logic [7:0] s_pixel_byte,
    input  logic [9:0] s_read_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte
);

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    mbb_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_cmd  (s_cmd),
        .m_ready(m_ready),
        .stat   (stat),
        .s_ready(s_ready),
        .cmd    (cmd)
    );

    mbb_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_start_req (s_start_req),
        .s_pixel_byte(s_pixel_byte),
        .s_read_index(s_read_index),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_frame_byte(m_frame_byte)
    );

endmodule

>>> src/mbb_checker.sv
// Port-level checks for the monochrome bitmap blit unit.
// Depends on the top level's ports only; attached by the bind at the end.
module mbb_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_cmd,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_frame_byte
);

    // The unit is busy with its clearing pass right after reset.
    a_busy_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high in the cycle after reset");

    // A read transaction is never taken while a result is stuck at the output.
    a_no_read_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_cmd && m_valid && !m_ready |-> !s_ready)
        else $error("read accepted while the output register is full");

    // A read transaction is followed by m_valid with its result.
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd |-> ##2 m_valid)
        else $error("read result did not appear");

    // A bitmap byte keeps the unit busy in the following cycle.
    a_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_cmd |=> !s_ready)
        else $error("s_ready high right after a bitmap byte");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte))
        else $error("stalled result changed or dropped");

endmodule

bind mono_bitmap_blit_to_page_buffer_unit mbb_checker u_mbb_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for mono_bitmap_blit_to_page_buffer_unit.
// Depends on mbb_pkg, the top level and the RTL below it; a shadow frame buffer
// predicts every read-back byte and a scoreboard class compares it.
`timescale 1ns / 1ps

module testbench;
    import mbb_pkg::*;

    localparam int RANDOM_ITEMS  = 600;
    localparam int CALM_TAIL     = 80;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;

    // Shadow of the frame buffer and blit position; holds the bytes that
    // reads are expected to return, oldest first.
    class blit_checker;
        logic [7:0] shadow_frame [STORE_SIZE];
        logic [4:0] byte_pos;
        logic [7:0] rows_done;
        logic       finished;
        logic [7:0] x_org;
        logic [7:0] y_org;
        logic [7:0] width_px;
        logic [7:0] height_px;
        logic [7:0] expected_bytes [$];
        int         failures;

        function new();
            foreach (shadow_frame[a]) shadow_frame[a] = 8'h00;
            byte_pos  = '0;
            rows_done = '0;
            finished  = 1'b0;
            x_org     = '0;
            y_org     = '0;
            width_px  = '0;
            height_px = '0;
            failures  = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                CFG_X_ORIGIN:   x_org = value;
                CFG_Y_ORIGIN:   y_org = value;
                CFG_BMP_WIDTH:  width_px = value;
                CFG_BMP_HEIGHT: height_px = value;
                default: ;
            endcase
        endfunction

        function void blit_byte(logic [7:0] data);
            int row_bytes;
            int i;
            int x;
            int y;
            int pos;
            row_bytes = (int'(width_px) + 7) >> 3;
            if (finished || width_px == 8'd0 || height_px == 8'd0) return;
            if (rows_done >= height_px) begin
                finished = 1'b1;
                return;
            end
            for (int b = 0; b < 8; b++) begin
                i = int'(byte_pos) * 8 + b;
                if (i < int'(width_px)) begin
                    x = (int'(x_org) + i) & 255;
                    y = (int'(y_org) + int'(rows_done)) & 255;
                    if (x < COLUMNS && y < ROWS) begin
                        pos = x * PAGES + (y >> 3);
                        shadow_frame[pos][y & 7] = data[7 - b];
                    end
                end
            end
            // A byte at or past the row length still closes the row.
            if (int'(byte_pos) + 1 >= row_bytes) begin
                byte_pos  = '0;
                rows_done = rows_done + 8'd1;
                if (rows_done >= height_px) finished = 1'b1;
            end else begin
                byte_pos = byte_pos + 5'd1;
            end
        endfunction

        function void note_accepted(logic cmd, logic start, logic [7:0] pix,
                                    logic [9:0] idx);
            if (cmd == CMD_READ) begin
                if (int'(idx) < STORE_SIZE) expected_bytes.push_back(shadow_frame[idx]);
                else expected_bytes.push_back(8'h00);
            end else begin
                if (start) begin
                    byte_pos  = '0;
                    rows_done = '0;
                    finished  = 1'b0;
                end
                blit_byte(pix);
            end
        endfunction

        function void check_frame_byte(logic [7:0] actual);
            logic [7:0] want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected frame_byte: expected none, actual %02h",
                         $time, actual);
                failures++;
            end else begin
                want = expected_bytes.pop_front();
                if (actual !== want) begin
                    $display("%0t: frame_byte mismatch: expected %02h, actual %02h",
                             $time, want, actual);
                    failures++;
                end
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_X_ORIGIN;
    logic [7:0] cfg_wdata = 8'h00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_cmd = CMD_WRITE;
    logic       s_start_req = 1'b0;
    logic [7:0] s_pixel_byte = 8'h00;
    logic [9:0] s_read_index = 10'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_frame_byte;

    blit_checker sb;
    int items_sent = 0;
    int idle_cycles = 0;
    bit no_idle = 1'b0;
    bit send_gaps = 1'b1;
    bit recv_calm = 1'b0;
    bit hold_request = 1'b0;

    mono_bitmap_blit_to_page_buffer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_start_req (s_start_req),
        .s_pixel_byte(s_pixel_byte),
        .s_read_index(s_read_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_frame_byte(m_frame_byte)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_frame_byte(m_frame_byte);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random ready bursts or steady ready, one long hold-off on request.
    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (no_idle || recv_calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic start, input logic [7:0] pix,
                             input logic [9:0] idx);
        if (!no_idle && send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_start_req  <= start;
        s_pixel_byte <= pix;
        s_read_index <= idx;
        do @(posedge aclk); while (!s_ready);
        sb.note_accepted(cmd, start, pix, idx);
        items_sent++;
    endtask

    task automatic wr(input logic start, input logic [7:0] pix);
        send_item(CMD_WRITE, start, pix, 10'($urandom_range(0, 1023)));
    endtask

    task automatic rd(input logic [9:0] idx);
        send_item(CMD_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), idx);
    endtask

    // Drain all reads, then give an ignored or in-flight write time to finish.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic load_config(input logic [7:0] xo, input logic [7:0] yo,
                               input logic [7:0] wd, input logic [7:0] ht);
        quiesce();
        write_reg(CFG_X_ORIGIN, xo);
        write_reg(CFG_Y_ORIGIN, yo);
        write_reg(CFG_BMP_WIDTH, wd);
        write_reg(CFG_BMP_HEIGHT, ht);
        cfg_we <= 1'b0;
    endtask

    // Half the reads aim at the area the current bitmap covers.
    function automatic logic [9:0] pick_index(logic [7:0] xo, logic [7:0] yo,
                                              logic [7:0] wd, logic [7:0] ht);
        int col;
        int page;
        if ($urandom_range(0, 1) == 0) return 10'($urandom_range(0, 1023));
        col  = (int'(xo) + int'($urandom_range(0, wd))) & 255;
        page = ((int'(yo) + int'($urandom_range(0, ht))) & 255) >> 3;
        if (col >= COLUMNS) col = $urandom_range(0, COLUMNS - 1);
        if (page >= PAGES) page = $urandom_range(0, PAGES - 1);
        return 10'(col * PAGES + page);
    endfunction

    task automatic random_phase(input bit squeeze);
        logic [7:0] xo;
        logic [7:0] yo;
        logic [7:0] wd;
        logic [7:0] ht;
        int row_bytes;
        int nsend;
        int k;
        bit fresh;
        case ($urandom_range(0, 5))
            0:       xo = 8'd0;
            1:       xo = 8'd255;
            2:       xo = 8'($urandom_range(100, 135));
            default: xo = 8'($urandom_range(0, COLUMNS - 1));
        endcase
        case ($urandom_range(0, 5))
            0:       yo = 8'd0;
            1:       yo = 8'd255;
            2:       yo = 8'($urandom_range(50, 70));
            default: yo = 8'($urandom_range(0, ROWS - 1));
        endcase
        case ($urandom_range(0, 9))
            0:       wd = 8'd0;
            1:       wd = 8'd255;
            2, 3:    wd = 8'($urandom_range(1, 8));
            default: wd = 8'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 9))
            0:       ht = 8'd0;
            1:       ht = 8'd255;
            default: ht = 8'($urandom_range(1, 12));
        endcase
        load_config(xo, yo, wd, ht);
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_calm = ($urandom_range(0, 3) == 0);
        fresh     = ($urandom_range(0, 9) != 0);

        // Large bitmaps are cut short; the next start request breaks them off.
        row_bytes = (int'(wd) + 7) >> 3;
        nsend = row_bytes * int'(ht);
        if (nsend == 0) nsend = 6;
        nsend = nsend + $urandom_range(0, 3);
        if (nsend > 80) nsend = 80;

        if (squeeze) begin
            hold_request = 1'b1;
            for (k = 0; k < 24; k++) rd(pick_index(xo, yo, wd, ht));
        end
        k = 0;
        while (k < nsend) begin
            if ($urandom_range(0, 9) < 3) begin
                rd(pick_index(xo, yo, wd, ht));
            end else begin
                wr((k == 0 && fresh) || $urandom_range(0, 39) == 0, 8'($urandom_range(0, 255)));
                k++;
            end
        end
        repeat (6) rd(pick_index(xo, yo, wd, ht));
    endtask

    initial begin
        int base;
        int phase;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Cleared buffer, and a write while width and height are still zero.
        rd(10'd0);
        rd(10'd1023);
        wr(1'b0, 8'hFF);

        // No start request yet: the bitmap begins at the reset position.
        load_config(8'd0, 8'd0, 8'd8, 8'd2);
        wr(1'b0, 8'hFF);
        wr(1'b0, 8'h81);
        wr(1'b0, 8'hFF);
        rd(10'd0);
        rd(10'(7 * PAGES));
        wr(1'b1, 8'h00);
        rd(10'd0);

        // Clipping at the right and bottom edges, with padding bits.
        load_config(8'd124, 8'd62, 8'd12, 8'd3);
        wr(1'b1, 8'hF0);
        wr(1'b0, 8'hFF);
        wr(1'b0, 8'hAA);
        wr(1'b0, 8'h55);
        wr(1'b0, 8'hFF);
        rd(10'(124 * PAGES + 7));
        rd(10'(127 * PAGES + 7));

        // Origin near 255 wraps part of the bitmap back to column and row zero.
        load_config(8'd250, 8'd255, 8'd16, 8'd2);
        wr(1'b1, 8'hFF);
        wr(1'b0, 8'hFF);
        wr(1'b0, 8'hC3);
        wr(1'b0, 8'hFF);
        rd(10'd0);

        // Width shrinks mid-row: the next byte only closes the row.
        load_config(8'd40, 8'd8, 8'd24, 8'd3);
        wr(1'b1, 8'hFF);
        wr(1'b0, 8'hFF);
        load_config(8'd40, 8'd8, 8'd8, 8'd3);
        wr(1'b0, 8'hFF);
        wr(1'b0, 8'h0F);
        rd(10'(44 * PAGES + 1));

        load_config(8'd0, 8'd0, 8'd8, 8'd0);
        wr(1'b1, 8'hFF);
        rd(10'd0);

        base  = items_sent;
        phase = 0;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base >= RANDOM_ITEMS - CALM_TAIL) no_idle = 1'b1;
            random_phase(phase == 2 && !no_idle);
            phase++;
        end

        quiesce();
        if (sb.pending() != 0)
            $display("%0t: %0d expected frame bytes never arrived", $time, sb.pending());
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
